>>> sv/rzs_pkg.sv
// Shared constants, codes and command struct for the rolling z-score spread signal.
// Depends on nothing; every other file imports it.
package rzs_pkg;

    // Window length and derived widths
    localparam int WINDOW   = 8;
    localparam int LOG_W    = $clog2(WINDOW);
    localparam int IDX_W    = LOG_W;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int PRICE_W  = 24;
    localparam int SPREAD_W = PRICE_W + 1;
    localparam int SUM_W    = SPREAD_W + LOG_W;
    localparam int SQR_W    = 2 * PRICE_W;
    localparam int SQ_W     = SQR_W + LOG_W;
    localparam int DMAG_W   = PRICE_W + LOG_W + 1;
    localparam int D_W      = DMAG_W + 1;
    localparam int PROD_W   = 2 * DMAG_W;
    localparam int VAR_W    = SQR_W + 2 * LOG_W;
    localparam int CMP_W    = PROD_W + 5;
    localparam int SIG_W    = 2;

    // |z| < 0.8 test as 25*d*d < 16*V
    localparam int INNER_NUM = 25;
    localparam int INNER_DEN = 16;

    // Result codes
    localparam logic [SIG_W-1:0] SIG_ABOVE  = 2'd0;
    localparam logic [SIG_W-1:0] SIG_BELOW  = 2'd1;
    localparam logic [SIG_W-1:0] SIG_INSIDE = 2'd2;
    localparam logic [SIG_W-1:0] SIG_NONE   = 2'd3;

    // Shared multiplier operand select
    localparam int MSEL_W = 2;
    localparam logic [MSEL_W-1:0] MSEL_X   = 2'd0;
    localparam logic [MSEL_W-1:0] MSEL_OLD = 2'd1;
    localparam logic [MSEL_W-1:0] MSEL_SUM = 2'd2;
    localparam logic [MSEL_W-1:0] MSEL_D   = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              full;
        logic [IDX_W-1:0]  slot;
        logic              mul_en;
        logic [MSEL_W-1:0] mul_sel;
        logic              scale;
        logic              commit;
        logic              out_load;
    } rzs_cmd_t;

endpackage

>>> sv/rzs_price_if.sv
// Input channel: one beat carries two prices.
// Depends on rzs_pkg for the price width.
interface rzs_price_if;
    import rzs_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price_a;
    logic [PRICE_W-1:0] price_b;

    modport source (output valid, output price_a, output price_b, input ready);
    modport sink   (input valid, input price_a, input price_b, output ready);
endinterface

>>> sv/rzs_signal_if.sv
// Output channel: one beat carries one signal code.
// Depends on rzs_pkg for the code width.
interface rzs_signal_if;
    import rzs_pkg::*;

    logic             valid;
    logic             ready;
    logic [SIG_W-1:0] signal;

    modport source (output valid, output signal, input ready);
    modport sink   (input valid, input signal, output ready);
endinterface

>>> sv/rzs_ctrl.sv
// Sequencer for the rolling z-score block: fill count, ring slot, output valid.
// Depends on rzs_pkg for widths and the command struct.
module rzs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output rzs_pkg::rzs_cmd_t cmd
);
    import rzs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_X = 3'd1;
    localparam logic [2:0] ST_MUL_O = 3'd2;
    localparam logic [2:0] ST_MUL_S = 3'd3;
    localparam logic [2:0] ST_MUL_D = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             score_reg, score_next;
    logic             out_valid_reg, out_valid_next;
    logic             full;

    assign full = (fill_reg == FULL_CNT);

    // Next-state and command decode
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        slot_next   = slot_reg;
        score_next  = score_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.slot    = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.full   = full;
                    score_next = full;
                    if (!full)
                        fill_next = fill_reg + 1'b1;
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_X;
                state_next  = ST_MUL_O;
            end
            ST_MUL_O:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_OLD;
                state_next  = ST_MUL_S;
            end
            ST_MUL_S:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_SUM;
                state_next  = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_D;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold while a scored result cannot enter the output register
                if (!score_reg || !out_valid_reg || out_ready)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = score_reg;
                    slot_next    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            score_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            score_reg     <= score_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/rzs_datapath.sv
// Datapath: spread ring memory, running sums, shared squarer and z-score compare.
// Depends on rzs_pkg for widths, codes and the command struct.
module rzs_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rzs_pkg::rzs_cmd_t          cmd,
    input  logic [rzs_pkg::PRICE_W-1:0] price_a,
    input  logic [rzs_pkg::PRICE_W-1:0] price_b,
    output logic [rzs_pkg::SIG_W-1:0]   signal
);
    import rzs_pkg::*;

    localparam logic signed [D_W-1:0] WIN_D = D_W'(WINDOW);

    // Spread ring, no reset: slots not yet written are never read
    logic signed [SPREAD_W-1:0] ring_mem [WINDOW];
    logic signed [SPREAD_W-1:0] old_reg;

    logic signed [SPREAD_W-1:0] x_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic signed [D_W-1:0]      d_reg;
    logic [SQR_W-1:0]           xx_reg;
    logic [SQR_W-1:0]           oo_reg;
    logic [VAR_W-1:0]           ss_reg;
    logic [PROD_W-1:0]          dd_reg;
    logic [VAR_W-1:0]           wq_reg;
    logic [VAR_W-1:0]           v_reg;
    logic [CMP_W-1:0]           dd25_reg;
    logic [CMP_W-1:0]           v16_reg;
    logic [SIG_W-1:0]           sig_reg;

    logic signed [SPREAD_W-1:0] x_next;
    logic [DMAG_W-1:0]          mul_op;
    logic [PROD_W-1:0]          mul_prod;
    logic signed [D_W-1:0]      d_next;
    logic [SIG_W-1:0]           sig_next;
    logic                       gt_unit;

    function automatic logic [DMAG_W-1:0] mag_of(input logic signed [D_W-1:0] v);
        logic signed [D_W-1:0] m;
        m = v[D_W-1] ? -v : v;
        return m[DMAG_W-1:0];
    endfunction

    assign x_next = $signed({1'b0, price_a}) - $signed({1'b0, price_b});
    assign d_next = WIN_D * D_W'(x_reg) - D_W'(sum_reg);

    // Shared squarer, operand chosen by the sequencer
    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_X:   mul_op = mag_of(D_W'(x_reg));
            MSEL_OLD: mul_op = mag_of(D_W'(old_reg));
            MSEL_SUM: mul_op = mag_of(D_W'(sum_reg));
            MSEL_D:   mul_op = mag_of(d_reg);
            default:  mul_op = '0;
        endcase
    end

    assign mul_prod = PROD_W'(mul_op) * PROD_W'(mul_op);

    // Classification from registered squares
    assign gt_unit = (CMP_W'(dd_reg) > CMP_W'(v_reg));

    always_comb
    begin
        if (gt_unit && !d_reg[D_W-1])
            sig_next = SIG_ABOVE;
        else if (gt_unit && d_reg[D_W-1])
            sig_next = SIG_BELOW;
        else if (dd25_reg < v16_reg)
            sig_next = SIG_INSIDE;
        else
            sig_next = SIG_NONE;
    end

    // Ring read on accept, write on commit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            old_reg <= cmd.full ? ring_mem[cmd.slot] : '0;
        if (cmd.commit)
            ring_mem[cmd.slot] <= x_reg;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= x_next;
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MSEL_X:
                begin
                    xx_reg <= mul_prod[SQR_W-1:0];
                    d_reg  <= d_next;
                end
                MSEL_OLD:
                begin
                    oo_reg <= mul_prod[SQR_W-1:0];
                end
                MSEL_SUM:
                begin
                    ss_reg <= mul_prod[VAR_W-1:0];
                    wq_reg <= VAR_W'(sq_reg) * VAR_W'(WINDOW);
                end
                MSEL_D:
                begin
                    dd_reg <= mul_prod;
                    v_reg  <= wq_reg - ss_reg;
                end
                default:
                begin
                    d_reg <= d_reg;
                end
            endcase
        end
        if (cmd.scale)
        begin
            dd25_reg <= CMP_W'(dd_reg) * CMP_W'(INNER_NUM);
            v16_reg  <= CMP_W'(v_reg) * CMP_W'(INNER_DEN);
        end
        if (cmd.out_load)
            sig_reg <= sig_next;
    end

    // Running sums over the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            sum_reg <= sum_reg - SUM_W'(old_reg) + SUM_W'(x_reg);
            sq_reg  <= sq_reg - SQ_W'(oo_reg) + SQ_W'(xx_reg);
        end
    end

    assign signal = sig_reg;

endmodule

>>> sv/rolling_zscore_spread_signal.sv
// Top level of the rolling z-score spread signal block.
// Depends on rzs_pkg, rzs_price_if, rzs_signal_if, rzs_ctrl and rzs_datapath.
//
//  channel  | dir | payload            | beat
//  ---------+-----+--------------------+----------------------------------
//  prices   | in  | price_a, price_b   | one pair of prices
//  result   | out | signal             | one code, only once the window is full
//
// Each item goes through an accept, four passes through the single
// shared squarer (x, oldest spread, window sum, deviation), one scale, one commit.
// Reset clears the sums, fill count, ring slot and sequencer at once; the ring
// itself needs no clearing since a slot is read only after it has been written.
// A waiting result does not block the next item; the sequencer holds at commit
// only if a second result would overwrite an unread one.
module rolling_zscore_spread_signal (
    input logic         clk,
    input logic         rst_n,
    rzs_price_if.sink   prices,
    rzs_signal_if.source result
);
    import rzs_pkg::*;

    rzs_cmd_t cmd;

    rzs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prices.valid),
        .in_ready  (prices.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    rzs_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .price_a (prices.price_a),
        .price_b (prices.price_b),
        .signal  (result.signal)
    );

endmodule

>>> sv/rzs_checker.sv
// Port-level checks for the rolling z-score block, bound to the top level.
// Depends on rzs_pkg for the code width.
module rzs_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [rzs_pkg::SIG_W-1:0] signal
);
    import rzs_pkg::*;

    // Result beat holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(signal))
        else $error("result payload changed while stalled");

    // One item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after accept");

    // A result never appears in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too soon after accept");

endmodule

bind rolling_zscore_spread_signal rzs_checker u_rzs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prices.valid),
    .in_ready  (prices.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .signal    (result.signal)
);

>>> bench/tb.sv
// Self-checking bench for rolling_zscore_spread_signal: price pairs in, signal codes out.
// Depends on rzs_pkg, rzs_price_if, rzs_signal_if and the block's top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rzs_pkg::*;

    // Tracks the spread window the block should hold and the signal codes still due
    class zscore_tracker_t;
        logic signed [SPREAD_W-1:0] spreads [WINDOW];
        logic signed [SUM_W-1:0]    spread_total;
        logic [SQ_W-1:0]            square_total;
        logic [CNT_W-1:0]           held;
        logic [IDX_W-1:0]           next_slot;

        logic [SIG_W-1:0] signals_due [$];
        int               pairs_taken;
        int               signals_seen;
        int               code_tally [4];
        int               errors;

        function new();
            foreach (spreads[i])
                spreads[i] = '0;
            spread_total = '0;
            square_total = '0;
            held         = '0;
            next_slot    = '0;
            pairs_taken  = 0;
            signals_seen = 0;
            errors       = 0;
            foreach (code_tally[i])
                code_tally[i] = 0;
        endfunction

        // One line per mismatch, and a count
        function void flag(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        // Exact z test by cross-multiplication against the window held now
        function logic [SIG_W-1:0] score_spread(logic signed [SPREAD_W-1:0] x);
            longint          dev;
            longint          var_scaled;
            longint unsigned dev_sq;
            dev        = longint'(WINDOW) * longint'(x) - longint'(spread_total);
            var_scaled = longint'(WINDOW) * longint'(square_total)
                         - longint'(spread_total) * longint'(spread_total);
            dev_sq     = (dev < 0) ? -dev : dev;
            dev_sq     = dev_sq * dev_sq;
            if (dev > 0 && dev_sq > var_scaled)
                return SIG_ABOVE;
            if (dev < 0 && dev_sq > var_scaled)
                return SIG_BELOW;
            if (INNER_NUM * dev_sq < INNER_DEN * var_scaled)
                return SIG_INSIDE;
            return SIG_NONE;
        endfunction

        // Accepted input beat: score first (once the window is full), then roll the window
        function void note_pair(logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
            logic signed [SPREAD_W-1:0] x;
            logic signed [SPREAD_W-1:0] oldest;
            x = $signed({1'b0, a}) - $signed({1'b0, b});
            pairs_taken++;
            if (held == WINDOW)
                signals_due.insert(signals_due.size(), score_spread(x));
            else
                held++;
            oldest       = spreads[next_slot];
            spread_total = spread_total - oldest + x;
            square_total = SQ_W'(longint'(square_total)
                                 - longint'(oldest) * longint'(oldest)
                                 + longint'(x) * longint'(x));
            spreads[next_slot] = x;
            next_slot = (next_slot == WINDOW - 1) ? '0 : next_slot + 1'b1;
        endfunction

        // Accepted output beat against the oldest code due
        function void check_signal(logic [SIG_W-1:0] got);
            logic [SIG_W-1:0] want;
            signals_seen++;
            code_tally[got]++;
            if (signals_due.size() == 0)
            begin
                flag($sformatf("signal %0d with nothing due", got));
                return;
            end
            want = signals_due.pop_front();
            if (got !== want)
                flag($sformatf("signal %0d, expected %0d (result %0d)",
                               got, want, signals_seen));
        endfunction
    endclass

    localparam int PERIOD     = 10;
    localparam int PRICE_MAX  = (1 << PRICE_W) - 1;
    localparam int PHASE_BEATS = 488;
    localparam int DRAIN      = 40;
    localparam int LIMIT      = 400000;

    typedef enum int {MODE_FREE, MODE_NOISY, MODE_FLAT, MODE_SWING} feed_mode_t;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   cycles = 0;

    zscore_tracker_t book;

    rzs_price_if  prices_ch ();
    rzs_signal_if result_ch ();

    rolling_zscore_spread_signal u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .prices (prices_ch),
        .result (result_ch)
    );

    initial clk = 1'b0;
    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    // Receiver backpressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= (int'($urandom_range(0, 99)) >= stall_pct);
    end

    // Output beats taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            book.check_signal(result_ch.signal);
    end

    // Watchdog
    initial
    begin
        wait (cycles >= LIMIT);
        $display("timeout after %0d cycles, %0d signals still due",
                 cycles, book.signals_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // One input beat, with random idle cycles ahead of it
    task automatic send_pair(input logic [PRICE_W-1:0] a, input logic [PRICE_W-1:0] b);
        while (int'($urandom_range(0, 99)) < idle_pct)
        begin
            prices_ch.valid <= 1'b0;
            @(negedge clk);
        end
        prices_ch.valid   <= 1'b1;
        prices_ch.price_a <= a;
        prices_ch.price_b <= b;
        do
            @(posedge clk);
        while (!prices_ch.ready);
        book.note_pair(a, b);
        @(negedge clk);
    endtask

    // Pick a price pair with the given spread, placed at random in the price range
    task automatic send_spread(input int s);
        int a;
        int b;
        if (s > PRICE_MAX)
            s = PRICE_MAX;
        if (s < -PRICE_MAX)
            s = -PRICE_MAX;
        if (s >= 0)
        begin
            b = int'($urandom_range(0, PRICE_MAX - s));
            a = b + s;
        end
        else
        begin
            a = int'($urandom_range(0, PRICE_MAX + s));
            b = a - s;
        end
        send_pair(PRICE_W'(a), PRICE_W'(b));
    endtask

    // Stop feeding until every due signal has come back
    task automatic drain_signals();
        prices_ch.valid <= 1'b0;
        while (book.signals_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Exact boundaries and corners
    task automatic run_directed();
        int k;
        int c;
        k = -300;
        c = 5 * 256;
        // warm-up on a flat window, then zero deviation with d = 0 and d > 0
        repeat (WINDOW)
            send_spread(k);
        send_spread(k);
        send_spread(k + 3);
        // alternating +c/-c window: mean 0, deviation c
        for (int i = 0; i < WINDOW; i++)
            send_spread((i % 2 == 0) ? c : -c);
        send_spread(c);
        send_spread(-c);
        send_spread(c * 4 / 5);
        send_spread(-(c * 3 / 4));
        // price extremes
        send_pair(PRICE_W'(PRICE_MAX), '0);
        send_pair('0, PRICE_W'(PRICE_MAX));
        send_pair('0, '0);
        send_pair(PRICE_W'(PRICE_MAX), PRICE_W'(PRICE_MAX));
    endtask

    // Segments of market-like spread series: noisy, flat, swinging, or unrelated prices
    task automatic run_random(input int beats);
        feed_mode_t mode;
        int         left;
        int         center;
        int         w;
        int         s;
        mode = MODE_FREE;
        left = 0;
        center = 0;
        w = 1;
        for (int i = 0; i < beats; i++)
        begin
            if (left == 0)
            begin
                mode = feed_mode_t'($urandom_range(0, 3));
                left = int'($urandom_range(4, 40));
                w    = 1 << $urandom_range(0, 16);
                if ($urandom_range(0, 1))
                    center = int'($urandom_range(0, 4000)) - 2000;
                else
                    center = int'($urandom_range(0, 2 * PRICE_MAX)) - PRICE_MAX;
            end
            left--;
            case (mode)
                MODE_FREE:
                    send_pair(PRICE_W'($urandom), PRICE_W'($urandom));
                MODE_NOISY:
                begin
                    s = center + int'($urandom_range(0, 2 * w)) - w;
                    if ($urandom_range(0, 7) == 0)
                        s += $urandom_range(0, 1) ? 3 * w : -3 * w;
                    send_spread(s);
                end
                MODE_FLAT:
                begin
                    // long flat runs give zero deviation, then a small step out
                    if ($urandom_range(0, 11) == 0)
                        center += $urandom_range(0, 1) ? 1 : -1;
                    send_spread(center);
                end
                default:
                    send_spread(center + ((i % 2 == 0) ? w : -w));
            endcase
        end
    endtask

    initial
    begin
        book = new();
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        prices_ch.valid = 1'b0;
        prices_ch.price_a = '0;
        prices_ch.price_b = '0;

        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no idling
        run_directed();
        run_random(PHASE_BEATS);
        drain_signals();

        // sender idles about half the time
        idle_pct = 49;
        stall_pct = 0;
        run_random(PHASE_BEATS);
        drain_signals();

        // receiver stalls about half the time
        idle_pct = 0;
        stall_pct = 49;
        run_random(PHASE_BEATS);
        drain_signals();

        // both sides gap
        idle_pct = 30;
        stall_pct = 30;
        run_random(PHASE_BEATS);
        drain_signals();

        repeat (DRAIN)
            @(posedge clk);

        $display("%0d price pairs over four idle/stall mixes, %0d signals checked",
                 book.pairs_taken, book.signals_seen);
        $display("signals: above %0d, below %0d, inside %0d, none %0d",
                 book.code_tally[SIG_ABOVE], book.code_tally[SIG_BELOW],
                 book.code_tally[SIG_INSIDE], book.code_tally[SIG_NONE]);
        if (book.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
